### rtl/core/blp_pkg.sv
package blp_pkg;

  localparam int unsigned LEVEL_W    = 7;
  localparam int unsigned MINUTE_W   = 11;
  localparam int unsigned TICKS_W    = 32;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned REASON_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned BOOT_WAIT_TICKS = 120;
  localparam int unsigned BOOT_W          = $clog2(BOOT_WAIT_TICKS + 1);

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(100);
  localparam logic [BOOT_W-1:0]  BOOT_LIMIT = BOOT_W'(BOOT_WAIT_TICKS);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_TOUCH  = 2'd1,
    FUNC_CONFIG = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [REASON_W-1:0] {
    REASON_DAY   = 3'd0,
    REASON_NIGHT = 3'd1,
    REASON_BOOT  = 3'd2,
    REASON_IDLE  = 3'd3,
    REASON_SETUP = 3'd4
  } reason_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DAY_LEVEL    = 3'd0,
    REG_NIGHT_LEVEL  = 3'd1,
    REG_NIGHT_START  = 3'd2,
    REG_NIGHT_END    = 3'd3,
    REG_SCREEN_OFF   = 3'd4,
    REG_WAKE_TOUCH   = 3'd5,
    REG_STORED_LEVEL = 3'd6,
    REG_UNUSED       = 3'd7
  } reg_idx_t;

  // Level-related settings the policy looks at.
  typedef struct packed {
    logic [LEVEL_W-1:0]  day_level;
    logic [LEVEL_W-1:0]  night_level;
    logic [MINUTE_W-1:0] win_start;
    logic [MINUTE_W-1:0] win_end;
  } policy_cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    reason_t            reason;
  } target_t;

  function automatic logic [LEVEL_W-1:0] cap_level(input logic [LEVEL_W-1:0] v);
    return (v > FULL_LEVEL) ? FULL_LEVEL : v;
  endfunction

  function automatic logic [LEVEL_W-1:0] load_stored(input logic [LEVEL_W-1:0] v);
    return (v != '0 && v <= FULL_LEVEL) ? v : FULL_LEVEL;
  endfunction

  // Start inclusive, end exclusive, wraps past midnight, off when equal.
  function automatic logic in_window(input logic [MINUTE_W-1:0] m,
                                     input logic [MINUTE_W-1:0] s,
                                     input logic [MINUTE_W-1:0] e);
    logic r;
    if (s == e)     r = 1'b0;
    else if (s < e) r = (m >= s) && (m < e);
    else            r = (m >= s) || (m < e);
    return r;
  endfunction

  function automatic target_t pick_level(input policy_cfg_t         c,
                                         input logic                synced,
                                         input logic [MINUTE_W-1:0] minute,
                                         input logic                setup,
                                         input logic                blank,
                                         input logic                cfgd,
                                         input logic [BOOT_W-1:0]   boot,
                                         input logic [LEVEL_W-1:0]  remembered);
    target_t t;
    logic    hold;
    hold = !synced && (!cfgd || (c.win_start != c.win_end)) && (boot < BOOT_LIMIT);
    if (setup) begin
      t.level  = FULL_LEVEL;
      t.reason = REASON_SETUP;
    end else if (blank) begin
      t.level  = '0;
      t.reason = REASON_IDLE;
    end else if (synced && in_window(minute, c.win_start, c.win_end)) begin
      t.level  = cap_level(c.night_level);
      t.reason = REASON_NIGHT;
    end else if (hold) begin
      t.level  = remembered;
      t.reason = REASON_BOOT;
    end else begin
      t.level  = cap_level(c.day_level);
      t.reason = REASON_DAY;
    end
    return t;
  endfunction

endpackage

### rtl/core/backlight_level_policy.sv
// Backlight level policy. Each input word is one event (tick, touch press or
// configuration applied) with the clock-sync flag, the local minute of day and
// the setup flag; each event yields exactly one result word. Level priority is
// setup (100), inactivity blank (0), synced night window, the remembered level
// during the boot hold, then the day level. Ticks advance the saturating idle
// counter and the boot-hold counter; touches on a dark panel are swallowed and
// may wake it. One event is taken per clock: the state update and the policy
// pick are a single pass of compare/select logic between the event input and
// the result register, and the input stalls only while a held result is itself
// stalled. Settings are written through the cfg port (always ready); the user
// must write them only while no event is in flight, unenforced by the block;
// a stored_level write reloads remembered_level (0 or above 100 loads as 100).
module backlight_level_policy (
  input  logic                              clk,
  input  logic                              rst,
  // event input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [blp_pkg::FUNC_W-1:0]        func,
  input  logic                              clock_synced,
  input  logic [blp_pkg::MINUTE_W-1:0]      minute_of_day,
  input  logic                              setup_on,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [blp_pkg::LEVEL_W-1:0]       level,
  output logic [blp_pkg::REASON_W-1:0]      reason,
  output logic                              applied,
  output logic                              consumed,
  output logic                              woke,
  output logic                              save_valid,
  output logic [blp_pkg::LEVEL_W-1:0]       save_level,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [blp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [blp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import blp_pkg::*;

  // settings
  policy_cfg_t          pcfg;
  logic [TICKS_W-1:0]   screen_off_ticks;
  logic                 touch_wake_en;

  // policy state
  logic [TICKS_W-1:0]   idle_count, idle_count_next;
  logic [BOOT_W-1:0]    boot_count, boot_count_next;
  logic                 blanked, blanked_next;
  logic                 configured_flag, configured_flag_next;
  logic [LEVEL_W-1:0]   applied_level, applied_level_next;
  logic [LEVEL_W-1:0]   remembered_level, remembered_level_next;
  reason_t              last_reason, last_reason_next;

  // result register
  logic [LEVEL_W-1:0]   r_level;
  reason_t              r_reason;
  logic                 r_applied, r_consumed, r_woke, r_save;
  logic [LEVEL_W-1:0]   r_save_level;

  logic                 in_accept;
  logic                 cfg_write;
  func_t                ev;
  logic                 do_apply, ev_consumed, ev_woke, ev_save;
  logic                 sel_blank, sel_cfgd;
  logic [BOOT_W-1:0]    sel_boot;
  logic [TICKS_W-1:0]   idle_inc;
  logic                 dark;
  target_t              tgt;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Result register empties or drains this cycle -> room for a new word.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign ev       = func_t'(func);
  assign dark     = (applied_level == '0);
  assign idle_inc = (idle_count != '1) ? idle_count + TICKS_W'(1) : idle_count;

  // Inputs to the single policy evaluation. A touch never sees the blank
  // (resume level), and its apply also runs with blanked cleared, so one
  // evaluation covers both the resume test and the apply.
  always_comb begin
    boot_count_next = boot_count;
    if (ev == FUNC_TICK && boot_count < BOOT_LIMIT)
      boot_count_next = boot_count + BOOT_W'(1);

    sel_boot  = boot_count_next;
    sel_cfgd  = configured_flag || (ev == FUNC_CONFIG);
    sel_blank = 1'b0;
    if (ev == FUNC_TICK)
      sel_blank = !setup_on &&
                  (blanked || (screen_off_ticks != '0 && idle_inc >= screen_off_ticks));
  end

  assign tgt = pick_level(pcfg, clock_synced, minute_of_day, setup_on,
                          sel_blank, sel_cfgd, sel_boot, remembered_level);

  always_comb begin
    idle_count_next      = idle_count;
    blanked_next         = blanked;
    configured_flag_next = configured_flag;
    do_apply             = 1'b0;
    ev_consumed          = 1'b0;
    ev_woke              = 1'b0;
    unique case (ev)
      FUNC_TICK: begin
        idle_count_next = setup_on ? '0 : idle_inc;
        blanked_next    = sel_blank;
        do_apply        = 1'b1;
      end
      FUNC_TOUCH: begin
        ev_consumed = dark;
        ev_woke     = dark && blanked && touch_wake_en && (tgt.level != '0);
        // dark with a zero resume target: the policy keeps it dark
        if (!dark || tgt.level == '0 || ev_woke)
          idle_count_next = '0;
        if (dark && (tgt.level == '0 || ev_woke)) begin
          blanked_next = 1'b0;
          do_apply     = 1'b1;
        end
      end
      FUNC_CONFIG: begin
        configured_flag_next = 1'b1;
        idle_count_next      = '0;
        blanked_next         = 1'b0;
        do_apply             = 1'b1;
      end
      default: ;
    endcase

    applied_level_next    = applied_level;
    last_reason_next      = last_reason;
    remembered_level_next = remembered_level;
    ev_save               = 1'b0;
    if (do_apply) begin
      applied_level_next = tgt.level;
      last_reason_next   = tgt.reason;
      // day or night pick that moves the remembered level gets persisted
      if ((tgt.reason == REASON_DAY || tgt.reason == REASON_NIGHT) &&
          tgt.level != '0 && tgt.level != remembered_level) begin
        remembered_level_next = tgt.level;
        ev_save               = 1'b1;
      end
    end
  end

  // settings registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pcfg.day_level   <= FULL_LEVEL;
      pcfg.night_level <= FULL_LEVEL;
      pcfg.win_start   <= '0;
      pcfg.win_end     <= '0;
      screen_off_ticks <= '0;
      touch_wake_en    <= 1'b1;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DAY_LEVEL:   pcfg.day_level   <= cfg_data[LEVEL_W-1:0];
        REG_NIGHT_LEVEL: pcfg.night_level <= cfg_data[LEVEL_W-1:0];
        REG_NIGHT_START: pcfg.win_start   <= cfg_data[MINUTE_W-1:0];
        REG_NIGHT_END:   pcfg.win_end     <= cfg_data[MINUTE_W-1:0];
        REG_SCREEN_OFF:  screen_off_ticks <= cfg_data[TICKS_W-1:0];
        REG_WAKE_TOUCH:  touch_wake_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // policy state
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_count       <= '0;
      boot_count       <= '0;
      blanked          <= 1'b0;
      configured_flag  <= 1'b0;
      applied_level    <= FULL_LEVEL;
      remembered_level <= FULL_LEVEL;
      last_reason      <= REASON_DAY;
    end else if (cfg_write && reg_idx_t'(cfg_index) == REG_STORED_LEVEL) begin
      remembered_level <= load_stored(cfg_data[LEVEL_W-1:0]);
    end else if (in_accept) begin
      idle_count       <= idle_count_next;
      boot_count       <= boot_count_next;
      blanked          <= blanked_next;
      configured_flag  <= configured_flag_next;
      applied_level    <= applied_level_next;
      remembered_level <= remembered_level_next;
      last_reason      <= last_reason_next;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      r_level      <= applied_level_next;
      r_reason     <= last_reason_next;
      r_applied    <= do_apply;
      r_consumed   <= ev_consumed;
      r_woke       <= ev_woke;
      r_save       <= ev_save;
      r_save_level <= remembered_level_next;
    end
  end

  assign level      = r_level;
  assign reason     = r_reason;
  assign applied    = r_applied;
  assign consumed   = r_consumed;
  assign woke       = r_woke;
  assign save_valid = r_save;
  assign save_level = r_save_level;

endmodule

### tb/backlight_level_policy_tb.sv
module backlight_level_policy_tb;
  import blp_pkg::*;

  // One result word as the block should return it.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    reason_t            reason;
    logic               applied;
    logic               consumed;
    logic               woke;
    logic               save_valid;
    logic [LEVEL_W-1:0] save_level;
  } backlight_result_t;

  logic clk = 1'b0;
  logic rst;

  logic                  in_valid;
  logic                  in_stall;
  logic [FUNC_W-1:0]     func;
  logic                  clock_synced;
  logic [MINUTE_W-1:0]   minute_of_day;
  logic                  setup_on;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LEVEL_W-1:0]    level;
  logic [REASON_W-1:0]   reason;
  logic                  applied;
  logic                  consumed;
  logic                  woke;
  logic                  save_valid;
  logic [LEVEL_W-1:0]    save_level;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  backlight_level_policy u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .clock_synced  (clock_synced),
    .minute_of_day (minute_of_day),
    .setup_on      (setup_on),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .level         (level),
    .reason        (reason),
    .applied       (applied),
    .consumed      (consumed),
    .woke          (woke),
    .save_valid    (save_valid),
    .save_level    (save_level),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 10 unit period, first rising edge at 5.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the settings and of the policy state.
  // ---------------------------------------------------------------------
  logic [LEVEL_W-1:0]  set_day;
  logic [LEVEL_W-1:0]  set_night;
  logic [MINUTE_W-1:0] set_start;
  logic [MINUTE_W-1:0] set_end;
  logic [TICKS_W-1:0]  set_off_ticks;
  logic                set_wake;
  logic [LEVEL_W-1:0]  set_stored;

  logic [TICKS_W-1:0]  idle_ticks;
  int unsigned         boot_ticks;
  logic                blank_flag;
  logic                cfgd_flag;
  logic [LEVEL_W-1:0]  lit_level;
  logic [LEVEL_W-1:0]  remembered;
  reason_t             last_why;

  backlight_result_t level_results_due[$];
  int                error_count = 0;

  // Percent chances, per cycle, of a sender gap and of a receiver stall.
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  function automatic logic [LEVEL_W-1:0] clamp_pct(input logic [LEVEL_W-1:0] v);
    return (v > FULL_LEVEL) ? FULL_LEVEL : v;
  endfunction

  // Priority pick; blank selects whether the inactivity blank counts.
  function automatic void pick_target(input logic synced, input logic [MINUTE_W-1:0] minute,
                                      input logic setup, input logic blank,
                                      output logic [LEVEL_W-1:0] lvl, output reason_t why);
    logic hold;
    logic night;
    hold = !synced && (!cfgd_flag || (set_start != set_end)) && (boot_ticks < BOOT_WAIT_TICKS);
    // start inclusive, end exclusive, wraps when start > end, off when equal
    if (set_start == set_end)     night = 1'b0;
    else if (set_start < set_end) night = (minute >= set_start) && (minute < set_end);
    else                          night = (minute >= set_start) || (minute < set_end);
    if (setup) begin
      lvl = FULL_LEVEL;
      why = REASON_SETUP;
    end else if (blank) begin
      lvl = '0;
      why = REASON_IDLE;
    end else if (synced && night) begin
      lvl = clamp_pct(set_night);
      why = REASON_NIGHT;
    end else if (hold) begin
      lvl = remembered;
      why = REASON_BOOT;
    end else begin
      lvl = clamp_pct(set_day);
      why = REASON_DAY;
    end
  endfunction

  // Drives the picked level; returns 1 when a new level must be persisted.
  function automatic logic drive_level(input logic synced, input logic [MINUTE_W-1:0] minute,
                                       input logic setup);
    logic [LEVEL_W-1:0] lvl;
    reason_t            why;
    pick_target(synced, minute, setup, blank_flag, lvl, why);
    lit_level = lvl;
    last_why  = why;
    if ((why == REASON_DAY || why == REASON_NIGHT) && lvl != '0 && lvl != remembered) begin
      remembered = lvl;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_backlight(input func_t f, input logic synced,
                                            input logic [MINUTE_W-1:0] minute,
                                            input logic setup,
                                            output backlight_result_t r);
    logic [LEVEL_W-1:0] resume_lvl;
    reason_t            resume_why;
    logic               dark;
    logic               keep_dark;
    logic               wake;
    r = '0;
    case (f)
      FUNC_TICK: begin
        if (boot_ticks < BOOT_WAIT_TICKS) boot_ticks++;
        if (idle_ticks != '1) idle_ticks++;
        if (setup) begin
          idle_ticks = '0;
          blank_flag = 1'b0;
        end else if (set_off_ticks != '0 && idle_ticks >= set_off_ticks) begin
          blank_flag = 1'b1;
        end
        r.save_valid = drive_level(synced, minute, setup);
        r.applied    = 1'b1;
      end
      FUNC_TOUCH: begin
        dark = (lit_level == '0);
        pick_target(synced, minute, setup, 1'b0, resume_lvl, resume_why);
        keep_dark  = dark && resume_lvl == '0;
        wake       = dark && blank_flag && set_wake && resume_lvl != '0;
        r.consumed = dark;
        r.woke     = wake;
        if (!dark || keep_dark || wake) idle_ticks = '0;
        if (keep_dark || wake) begin
          blank_flag   = 1'b0;
          r.save_valid = drive_level(synced, minute, setup);
          r.applied    = 1'b1;
        end
      end
      FUNC_CONFIG: begin
        cfgd_flag    = 1'b1;
        idle_ticks   = '0;
        blank_flag   = 1'b0;
        r.save_valid = drive_level(synced, minute, setup);
        r.applied    = 1'b1;
      end
      default: ; // unused code leaves everything alone
    endcase
    r.level      = lit_level;
    r.reason     = last_why;
    r.save_level = remembered;
  endfunction

  function automatic void shadow_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_DAY_LEVEL:    set_day       = d[LEVEL_W-1:0];
      REG_NIGHT_LEVEL:  set_night     = d[LEVEL_W-1:0];
      REG_NIGHT_START:  set_start     = d[MINUTE_W-1:0];
      REG_NIGHT_END:    set_end       = d[MINUTE_W-1:0];
      REG_SCREEN_OFF:   set_off_ticks = d[TICKS_W-1:0];
      REG_WAKE_TOUCH:   set_wake      = d[0];
      REG_STORED_LEVEL: begin
        set_stored = d[LEVEL_W-1:0];
        // zero or above full loads as full
        remembered = (set_stored != '0 && set_stored <= FULL_LEVEL) ? set_stored : FULL_LEVEL;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driving: everything changes at the falling edge.
  // ---------------------------------------------------------------------
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_write(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Sends one event word; the expectation is queued at the accepting edge.
  task automatic send_event(input func_t f, input logic synced,
                            input logic [MINUTE_W-1:0] minute, input logic setup);
    backlight_result_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    func          = f;
    clock_synced  = synced;
    minute_of_day = minute;
    setup_on      = setup;
    in_valid      = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_backlight(f, synced, minute, setup, r);
    level_results_due.push_back(r);
  endtask

  // Settings only move while nothing is in flight.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (level_results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Receiver backpressure, redrawn every falling edge.
  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < sink_stall_pct);
  end

  // ---------------------------------------------------------------------
  // Result checking at the rising edge.
  // ---------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_checker
    backlight_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (level_results_due.size() == 0) begin
        $error("result word with nothing outstanding: level %0d reason %0d", level, reason);
        error_count++;
      end else begin
        want = level_results_due.pop_front();
        check_field("level", 32'(want.level), 32'(level));
        check_field("reason", 32'(want.reason), 32'(reason));
        check_field("applied", 32'(want.applied), 32'(applied));
        check_field("consumed", 32'(want.consumed), 32'(consumed));
        check_field("woke", 32'(want.woke), 32'(woke));
        check_field("save_valid", 32'(want.save_valid), 32'(save_valid));
        check_field("save_level", 32'(want.save_level), 32'(save_level));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------

  // Boot hold right after reset, stored level loading, first configured event.
  task automatic test_boot_hold();
    send_event(FUNC_TICK, 1'b0, 11'd0, 1'b0);       // unconfigured, unsynced: hold at 100
    send_event(FUNC_TOUCH, 1'b0, 11'd0, 1'b0);      // lit panel, just activity
    send_event(FUNC_NONE, 1'b1, 11'd2047, 1'b1);    // unused code, nothing moves
    wait_idle();
    write_reg(REG_STORED_LEVEL, 32'd0);             // zero loads as full
    send_event(FUNC_NONE, 1'b0, 11'd0, 1'b0);
    wait_idle();
    write_reg(REG_STORED_LEVEL, 32'd127);           // above full loads as full
    write_reg(REG_NIGHT_LEVEL, 32'd127);            // used as 100
    write_reg(REG_STORED_LEVEL, 32'd37);
    send_event(FUNC_TICK, 1'b0, 11'd5, 1'b0);       // hold shows 37
    send_event(FUNC_CONFIG, 1'b0, 11'd5, 1'b0);     // configured, no window: day, save
    wait_idle();
    write_reg(REG_STORED_LEVEL, 32'd37);
    write_reg(REG_NIGHT_START, 32'd1380);
    write_reg(REG_NIGHT_END, 32'd360);
    send_event(FUNC_TICK, 1'b0, 11'd1400, 1'b0);    // configured with a window: hold again
    send_event(FUNC_TICK, 1'b1, 11'd1380, 1'b0);    // synced at window start: night, capped
  endtask

  // Priority order, window edges, inactivity blank, minutes past the day.
  task automatic test_level_priority();
    wait_idle();
    write_reg(REG_DAY_LEVEL, 32'd60);
    write_reg(REG_NIGHT_LEVEL, 32'd20);
    write_reg(REG_NIGHT_START, 32'd600);
    write_reg(REG_NIGHT_END, 32'd610);
    write_reg(REG_SCREEN_OFF, 32'd2);
    write_reg(REG_WAKE_TOUCH, 32'd1);
    send_event(FUNC_CONFIG, 1'b1, 11'd599, 1'b0);   // day, idle cleared
    send_event(FUNC_TICK, 1'b1, 11'd600, 1'b0);     // start inclusive: night
    send_event(FUNC_TICK, 1'b1, 11'd610, 1'b0);     // idle reaches timeout: blank
    send_event(FUNC_TICK, 1'b0, 11'd0, 1'b1);       // setup beats blank, clears idle
    wait_idle();
    write_reg(REG_NIGHT_START, 32'd1000);
    write_reg(REG_NIGHT_END, 32'd200);
    write_reg(REG_SCREEN_OFF, 32'd0);               // timer off
    send_event(FUNC_TICK, 1'b1, 11'd2047, 1'b0);    // past 1439, wrapped window: night
    send_event(FUNC_TICK, 1'b1, 11'd200, 1'b0);     // end exclusive: day
    wait_idle();
    write_reg(REG_NIGHT_END, 32'd1000);             // start equals end: window off
    send_event(FUNC_TICK, 1'b1, 11'd1000, 1'b0);
  endtask

  // Touch paths: wake, swallowed without wake, policy keeps it dark.
  task automatic test_touch_wake();
    wait_idle();
    write_reg(REG_SCREEN_OFF, 32'd1);
    send_event(FUNC_TICK, 1'b1, 11'd300, 1'b0);     // idle already at the timeout: blank
    send_event(FUNC_TOUCH, 1'b1, 11'd300, 1'b0);    // dark and blanked: wakes
    wait_idle();
    write_reg(REG_WAKE_TOUCH, 32'hFFFF_FFFE);       // bit 0 clear: no wake
    send_event(FUNC_TICK, 1'b1, 11'd300, 1'b0);
    send_event(FUNC_TOUCH, 1'b1, 11'd300, 1'b0);    // swallowed, stays blank
    wait_idle();
    write_reg(REG_DAY_LEVEL, 32'd0);
    write_reg(REG_SCREEN_OFF, 32'hFFFF_FFFF);
    send_event(FUNC_CONFIG, 1'b1, 11'd300, 1'b0);   // day level 0, no save
    send_event(FUNC_TOUCH, 1'b1, 11'd300, 1'b0);    // dark with resume 0: kept dark
  endtask

  // ---------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------
  function automatic logic [CFG_DATA_W-1:0] pad_bits(input logic [CFG_DATA_W-1:0] v,
                                                     input int w);
    logic [CFG_DATA_W-1:0] hi;
    hi = $urandom;
    return ((hi >> w) << w) | v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_pct();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'd100;
      2:       return 32'd101;
      3:       return 32'd127;
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  // Setting 0 is top values but a window end of 0, setting 1 all bottom values, others random.
  task automatic randomize_settings(input int k);
    logic [CFG_DATA_W-1:0] day_v, night_v, start_v, end_v, off_v, wake_v, stored_v;
    int r;
    if (k == 0) begin
      day_v = 127; night_v = 127; start_v = 1439; end_v = 0;
      off_v = 32'hFFFF_FFFF; wake_v = 1; stored_v = 127;
    end else if (k == 1) begin
      day_v = 0; night_v = 0; start_v = 0; end_v = 0;
      off_v = 0; wake_v = 0; stored_v = 0;
    end else begin
      day_v    = pick_pct();
      night_v  = pick_pct();
      stored_v = pick_pct();
      wake_v   = $urandom_range(0, 1);
      start_v  = ($urandom_range(0, 99) < 5) ? $urandom_range(1440, 2047)
                                             : $urandom_range(0, 1439);
      r = $urandom_range(0, 99);
      if (r < 15)      end_v = start_v;
      else if (r < 25) end_v = $urandom_range(0, 2047);
      else             end_v = $urandom_range(0, 1439);
      r = $urandom_range(0, 99);
      if (r < 70)      off_v = $urandom_range(1, 12);
      else if (r < 80) off_v = 0;
      else if (r < 90) off_v = 32'hFFFF_FFFF;
      else             off_v = $urandom;
    end
    write_reg(REG_DAY_LEVEL, pad_bits(day_v, LEVEL_W));
    write_reg(REG_NIGHT_LEVEL, pad_bits(night_v, LEVEL_W));
    write_reg(REG_NIGHT_START, pad_bits(start_v, MINUTE_W));
    write_reg(REG_NIGHT_END, pad_bits(end_v, MINUTE_W));
    write_reg(REG_SCREEN_OFF, off_v);
    write_reg(REG_WAKE_TOUCH, pad_bits(wake_v, 1));
    write_reg(REG_STORED_LEVEL, pad_bits(stored_v, LEVEL_W));
    write_reg(REG_UNUSED, $urandom);                // no register behind it
  endtask

  // Mostly ticks and touches, minutes often right on the window edges.
  task automatic send_random_event();
    int                  r;
    func_t               f;
    logic                s;
    logic                u;
    logic [MINUTE_W-1:0] m;
    r = $urandom_range(0, 99);
    if (r < 50)      f = FUNC_TICK;
    else if (r < 75) f = FUNC_TOUCH;
    else if (r < 88) f = FUNC_CONFIG;
    else             f = FUNC_NONE;
    s = ($urandom_range(0, 99) < 75);
    u = ($urandom_range(0, 99) < 8);
    r = $urandom_range(0, 99);
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0:       m = set_start - MINUTE_W'(1);
        1:       m = set_start;
        2:       m = set_end - MINUTE_W'(1);
        default: m = set_end;
      endcase
    end else if (r < 95) begin
      m = MINUTE_W'($urandom_range(0, 1439));
    end else begin
      m = MINUTE_W'($urandom_range(1440, 2047));
    end
    send_event(f, s, m, u);
  endtask

  // Two settings per phase, each followed by a burst of random events.
  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int first_k);
    wait_idle();
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    for (int k = first_k; k < first_k + 2; k++) begin
      wait_idle();
      randomize_settings(k);
      repeat (88) send_random_event();
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    func          = FUNC_NONE;
    clock_synced  = 1'b0;
    minute_of_day = '0;
    setup_on      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_UNUSED;
    cfg_data      = '0;

    // shadow state as the block comes out of reset
    set_day       = FULL_LEVEL;
    set_night     = FULL_LEVEL;
    set_start     = '0;
    set_end       = '0;
    set_off_ticks = '0;
    set_wake      = 1'b1;
    set_stored    = FULL_LEVEL;
    idle_ticks    = '0;
    boot_ticks    = 0;
    blank_flag    = 1'b0;
    cfgd_flag     = 1'b0;
    lit_level     = FULL_LEVEL;
    remembered    = FULL_LEVEL;
    last_why      = REASON_DAY;

    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_boot_hold();
    test_level_priority();
    test_touch_wake();
    test_random_traffic(0, 0, 0);     // back to back
    test_random_traffic(53, 0, 2);    // sender gaps
    test_random_traffic(0, 53, 4);    // receiver stalls
    test_random_traffic(29, 29, 6);   // both

    // drain, then wait for any stray word
    wait_idle();
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
